// ----- hdl/icmpv6_to_icmpv4_header_translate_macros.svh -----
// Assertion macros for the ICMPv6 to ICMPv4 header translator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ICMPV6_TO_ICMPV4_HEADER_TRANSLATE_MACROS_SVH
`define ICMPV6_TO_ICMPV4_HEADER_TRANSLATE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define ICMP64_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icmp64 same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define ICMP64_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icmp64 next-cycle check failed");

`endif

// ----- hdl/icmp64_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, message codes and the parameter-problem pointer table
// for the ICMPv6 to ICMPv4 header translator. No dependencies.
package icmp64_pkg;

   // Field widths
   localparam int TYPE_W  = 8;
   localparam int CODE_W  = 8;
   localparam int REST_W  = 32;
   localparam int MTU_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IPV4_LINK_MTU = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IPV6_LINK_MTU = 2'd1;
   localparam logic [MTU_W-1:0] IPV4_MTU_RESET = 16'd1500;
   localparam logic [MTU_W-1:0] IPV6_MTU_RESET = 16'd1500;

   // ICMPv6 types
   localparam logic [TYPE_W-1:0] V6_DEST_UNREACH = 8'd1;
   localparam logic [TYPE_W-1:0] V6_PKT_TOO_BIG  = 8'd2;
   localparam logic [TYPE_W-1:0] V6_TIME_EXCEED  = 8'd3;
   localparam logic [TYPE_W-1:0] V6_PARAM_PROB   = 8'd4;
   localparam logic [TYPE_W-1:0] V6_ECHO_REQ     = 8'd128;
   localparam logic [TYPE_W-1:0] V6_ECHO_REP     = 8'd129;

   // ICMPv6 codes
   localparam logic [CODE_W-1:0] V6C_NO_ROUTE    = 8'd0;
   localparam logic [CODE_W-1:0] V6C_ADMIN       = 8'd1;
   localparam logic [CODE_W-1:0] V6C_SCOPE       = 8'd2;
   localparam logic [CODE_W-1:0] V6C_ADDR        = 8'd3;
   localparam logic [CODE_W-1:0] V6C_PORT        = 8'd4;
   localparam logic [CODE_W-1:0] V6C_PP_HEADER   = 8'd0;
   localparam logic [CODE_W-1:0] V6C_PP_NEXTHDR  = 8'd1;
   localparam logic [CODE_W-1:0] V6C_ZERO        = 8'd0;
   localparam logic [CODE_W-1:0] V6C_TE_MAX      = 8'd1;

   // ICMPv4 types
   localparam logic [TYPE_W-1:0] V4_ECHO_REP     = 8'd0;
   localparam logic [TYPE_W-1:0] V4_DEST_UNREACH = 8'd3;
   localparam logic [TYPE_W-1:0] V4_ECHO_REQ     = 8'd8;
   localparam logic [TYPE_W-1:0] V4_TIME_EXCEED  = 8'd11;
   localparam logic [TYPE_W-1:0] V4_PARAM_PROB   = 8'd12;

   // ICMPv4 codes
   localparam logic [CODE_W-1:0] V4C_ZERO        = 8'd0;
   localparam logic [CODE_W-1:0] V4C_HOST_UNREACH = 8'd1;
   localparam logic [CODE_W-1:0] V4C_PROTO_UNREACH = 8'd2;
   localparam logic [CODE_W-1:0] V4C_PORT_UNREACH = 8'd3;
   localparam logic [CODE_W-1:0] V4C_FRAG_NEEDED = 8'd4;
   localparam logic [CODE_W-1:0] V4C_HOST_PROHIB = 8'd10;

   // MTU arithmetic
   localparam logic [MTU_W-1:0] MTU_HDR_DELTA = 16'd20;
   localparam logic [MTU_W-1:0] MTU_FLOOR     = 16'd68;

   // How the rest-of-header word is treated downstream
   typedef enum logic [2:0] {
      KIND_ZERO,   // must be all zero, output zero
      KIND_ECHO,   // copied
      KIND_PTB,    // carries an MTU
      KIND_PPTR,   // carries a mapped pointer
      KIND_PFREE   // not checked, output zero
   } kind_type;

   typedef struct packed {
      logic                ok;
      logic                echo;
      kind_type            kind;
      logic [TYPE_W-1:0]   nt;
      logic [CODE_W-1:0]   nc;
      logic [REST_W-1:0]   rest;
      logic [MTU_W-1:0]    mtu;
   } item_type;

   typedef struct packed {
      logic [MTU_W-1:0] ipv4_mtu;
      logic [MTU_W-1:0] ipv6_mtu;
   } cfg_type;

   typedef struct packed {
      logic                accepted;
      logic [TYPE_W-1:0]   icmp4_type;
      logic [CODE_W-1:0]   icmp4_code;
      logic [REST_W-1:0]   rest_out;
      logic                is_error_message;
   } res_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] np;
   } ptr_type;

   // Parameter-problem pointer translation (IPv6 header offset -> IPv4)
   function automatic ptr_type ptr_map(input logic [7:0] p);
      ptr_type r;
      r.ok = 1'b1;
      r.np = 8'd0;
      if (p <= 8'd1) begin
         r.np = p;
      end else if (p == 8'd4 || p == 8'd5) begin
         r.np = 8'd2;
      end else if (p == 8'd6) begin
         r.np = 8'd9;
      end else if (p == 8'd7) begin
         r.np = 8'd8;
      end else if (p >= 8'd8 && p <= 8'd23) begin
         r.np = 8'd12;
      end else if (p >= 8'd24 && p <= 8'd39) begin
         r.np = 8'd16;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hdl/icmp64_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on icmp64_pkg for field widths.
interface icmp64_req_if;
   logic                           valid;
   logic                           ready;
   logic [icmp64_pkg::TYPE_W-1:0]  msg_type;
   logic [icmp64_pkg::CODE_W-1:0]  msg_code;
   logic [icmp64_pkg::REST_W-1:0]  rest_in;

   modport source (output valid, msg_type, msg_code, rest_in, input ready);
   modport sink   (input valid, msg_type, msg_code, rest_in, output ready);
endinterface

interface icmp64_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [icmp64_pkg::TYPE_W-1:0]  icmp4_type;
   logic [icmp64_pkg::CODE_W-1:0]  icmp4_code;
   logic [icmp64_pkg::REST_W-1:0]  rest_out;
   logic                           is_error_message;

   modport source (output valid, accepted, icmp4_type, icmp4_code, rest_out,
                   is_error_message, input ready);
   modport sink   (input valid, accepted, icmp4_type, icmp4_code, rest_out,
                   is_error_message, output ready);
endinterface

// ----- hdl/icmp64_decode.sv -----
`timescale 1ns / 1ps
// Stage 1: type/code mapping, rest-of-header checks, pointer table, MTU - 20.
// Depends on icmp64_pkg.
module icmp64_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [icmp64_pkg::TYPE_W-1:0] msg_type,
   input  logic [icmp64_pkg::CODE_W-1:0] msg_code,
   input  logic [icmp64_pkg::REST_W-1:0] rest_in,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output icmp64_pkg::item_type          dn_item
);

   logic                 valid_ff, valid_in;
   icmp64_pkg::item_type item_ff, item_in;
   icmp64_pkg::ptr_type  ptr;
   logic [icmp64_pkg::MTU_W-1:0] m;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign ptr      = icmp64_pkg::ptr_map(rest_in[7:0]);
   assign m        = rest_in[icmp64_pkg::MTU_W-1:0];

   always_comb begin
      item_in      = '0;
      item_in.kind = icmp64_pkg::KIND_ZERO;
      case (msg_type)
         icmp64_pkg::V6_ECHO_REQ: begin
            item_in.nt   = icmp64_pkg::V4_ECHO_REQ;
            item_in.ok   = (msg_code == icmp64_pkg::V6C_ZERO);
            item_in.kind = icmp64_pkg::KIND_ECHO;
            item_in.echo = 1'b1;
         end
         icmp64_pkg::V6_ECHO_REP: begin
            item_in.nt   = icmp64_pkg::V4_ECHO_REP;
            item_in.ok   = (msg_code == icmp64_pkg::V6C_ZERO);
            item_in.kind = icmp64_pkg::KIND_ECHO;
            item_in.echo = 1'b1;
         end
         icmp64_pkg::V6_DEST_UNREACH: begin
            item_in.nt = icmp64_pkg::V4_DEST_UNREACH;
            item_in.ok = 1'b1;
            case (msg_code)
               icmp64_pkg::V6C_NO_ROUTE,
               icmp64_pkg::V6C_SCOPE,
               icmp64_pkg::V6C_ADDR:  item_in.nc = icmp64_pkg::V4C_HOST_UNREACH;
               icmp64_pkg::V6C_ADMIN: item_in.nc = icmp64_pkg::V4C_HOST_PROHIB;
               icmp64_pkg::V6C_PORT:  item_in.nc = icmp64_pkg::V4C_PORT_UNREACH;
               default:               item_in.ok = 1'b0;
            endcase
         end
         icmp64_pkg::V6_PKT_TOO_BIG: begin
            item_in.nt   = icmp64_pkg::V4_DEST_UNREACH;
            item_in.nc   = icmp64_pkg::V4C_FRAG_NEEDED;
            item_in.ok   = (msg_code == icmp64_pkg::V6C_ZERO);
            item_in.kind = icmp64_pkg::KIND_PTB;
         end
         icmp64_pkg::V6_TIME_EXCEED: begin
            item_in.nt = icmp64_pkg::V4_TIME_EXCEED;
            item_in.nc = msg_code;
            item_in.ok = (msg_code <= icmp64_pkg::V6C_TE_MAX);
         end
         icmp64_pkg::V6_PARAM_PROB: begin
            case (msg_code)
               icmp64_pkg::V6C_PP_HEADER: begin
                  item_in.nt   = icmp64_pkg::V4_PARAM_PROB;
                  item_in.ok   = 1'b1;
                  item_in.kind = icmp64_pkg::KIND_PPTR;
               end
               icmp64_pkg::V6C_PP_NEXTHDR: begin
                  item_in.nt   = icmp64_pkg::V4_DEST_UNREACH;
                  item_in.nc   = icmp64_pkg::V4C_PROTO_UNREACH;
                  item_in.ok   = 1'b1;
                  item_in.kind = icmp64_pkg::KIND_PFREE;
               end
               default: item_in.ok = 1'b0;
            endcase
         end
         default: item_in.ok = 1'b0;
      endcase

      // Rest-of-header checks and pre-formatting
      case (item_in.kind)
         icmp64_pkg::KIND_ECHO: item_in.rest = rest_in;
         icmp64_pkg::KIND_PTB: begin
            item_in.ok  = item_in.ok && (rest_in[31:16] == 16'd0);
            item_in.mtu = (m < icmp64_pkg::MTU_HDR_DELTA) ? '0
                          : m - icmp64_pkg::MTU_HDR_DELTA;
         end
         icmp64_pkg::KIND_PPTR: begin
            item_in.ok   = item_in.ok && (rest_in[31:8] == 24'd0) && ptr.ok;
            item_in.rest = {ptr.np, 24'd0};
         end
         icmp64_pkg::KIND_PFREE: item_in.rest = '0;
         default: item_in.ok = item_in.ok && (rest_in == '0);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ----- hdl/icmp64_mtu.sv -----
`timescale 1ns / 1ps
// Stage 2: clamps the packet-too-big MTU against both link MTU bounds.
// Depends on icmp64_pkg.
module icmp64_mtu (
   input  logic                 clock,
   input  logic                 reset,
   input  icmp64_pkg::cfg_type  cfg,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  icmp64_pkg::item_type up_item,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output icmp64_pkg::item_type dn_item
);

   logic                 valid_ff, valid_in;
   icmp64_pkg::item_type item_ff, item_in;
   logic [icmp64_pkg::MTU_W-1:0] v4_min, b6;
   logic                         b6_neg;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // An IPv6 bound below zero always wins and lands on the floor later.
   assign b6_neg = cfg.ipv6_mtu < icmp64_pkg::MTU_HDR_DELTA;
   assign b6     = cfg.ipv6_mtu - icmp64_pkg::MTU_HDR_DELTA;
   assign v4_min = (up_item.mtu > cfg.ipv4_mtu) ? cfg.ipv4_mtu : up_item.mtu;

   always_comb begin
      item_in = up_item;
      if (b6_neg) begin
         item_in.mtu = '0;
      end else if (v4_min > b6) begin
         item_in.mtu = b6;
      end else begin
         item_in.mtu = v4_min;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

// ----- hdl/icmp64_out.sv -----
`timescale 1ns / 1ps
// Stage 3: MTU floor, rest-of-header assembly, reject zeroing; output register.
// Depends on icmp64_pkg.
module icmp64_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  icmp64_pkg::item_type up_item,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output icmp64_pkg::res_type  dn_res
);

   logic                         valid_ff, valid_in;
   icmp64_pkg::res_type          res_ff, res_in;
   logic [icmp64_pkg::MTU_W-1:0] mtu_fl;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign mtu_fl   = (up_item.mtu < icmp64_pkg::MTU_FLOOR) ? icmp64_pkg::MTU_FLOOR
                     : up_item.mtu;

   always_comb begin
      res_in = '0;
      if (up_item.ok) begin
         res_in.accepted         = 1'b1;
         res_in.icmp4_type       = up_item.nt;
         res_in.icmp4_code       = up_item.nc;
         res_in.is_error_message = !up_item.echo;
         if (up_item.kind == icmp64_pkg::KIND_PTB) begin
            res_in.rest_out = {16'd0, mtu_fl};
         end else begin
            res_in.rest_out = up_item.rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         res_ff <= res_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_res   = res_ff;

endmodule

// ----- hdl/icmpv6_to_icmpv4_header_translate.sv -----
`timescale 1ns / 1ps
// ICMPv6 to ICMPv4 header translator, top level: link MTU registers and
// the three-stage pipeline. Depends on icmp64_pkg, icmp64_if, stage modules.
//
// Usage:
//  - req_chan carries one item per ICMPv6 header (type, code, bytes 4..7);
//    rsp_chan returns exactly one item per request, in order: accepted flag,
//    ICMPv4 type, code, rest-of-header and the error-message flag. A reject
//    comes back with every field zero.
//  - csr_we/csr_index/csr_wdata write the link MTUs: index 0 is the IPv4
//    link MTU, index 1 the IPv6 link MTU; other indexes are ignored. Write
//    only while no item is in flight.
//  - Pipeline: three register stages (decode, MTU clamp, output register).
//    Throughput: one item per cycle unless rsp_chan stalls; each stage is
//    a single register with its own valid bit, so bubbles collapse and a
//    full pipeline streams.
//  - Stall: when rsp_chan.ready is low, the output register holds its item
//    and the earlier stages keep filling; req_chan.ready drops only once all
//    three stages hold items. Nothing is dropped or repeated.
//  - Reset (synchronous, active high): clears all stage valid bits and sets
//    both link MTUs to 1500.
`include "icmpv6_to_icmpv4_header_translate_macros.svh"

module icmpv6_to_icmpv4_header_translate (
   input  logic                               clock,
   input  logic                               reset,
   icmp64_req_if.sink                         req_chan,
   icmp64_rsp_if.source                       rsp_chan,
   input  logic                               csr_we,
   input  logic [icmp64_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [icmp64_pkg::MTU_W-1:0]       csr_wdata
);

   // Link MTU registers
   logic [icmp64_pkg::MTU_W-1:0] ipv4_mtu_ff, ipv4_mtu_in;
   logic [icmp64_pkg::MTU_W-1:0] ipv6_mtu_ff, ipv6_mtu_in;
   icmp64_pkg::cfg_type          cfg;

   // Stage-to-stage handshake
   logic                 s1_valid, s1_ready;
   logic                 s2_valid, s2_ready;
   icmp64_pkg::item_type s1_item, s2_item;
   icmp64_pkg::res_type  res;

   always_comb begin
      ipv4_mtu_in = ipv4_mtu_ff;
      ipv6_mtu_in = ipv6_mtu_ff;
      if (csr_we) begin
         case (csr_index)
            icmp64_pkg::CSR_IPV4_LINK_MTU: ipv4_mtu_in = csr_wdata;
            icmp64_pkg::CSR_IPV6_LINK_MTU: ipv6_mtu_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_mtu_ff <= icmp64_pkg::IPV4_MTU_RESET;
         ipv6_mtu_ff <= icmp64_pkg::IPV6_MTU_RESET;
      end else begin
         ipv4_mtu_ff <= ipv4_mtu_in;
         ipv6_mtu_ff <= ipv6_mtu_in;
      end
   end

   assign cfg.ipv4_mtu = ipv4_mtu_ff;
   assign cfg.ipv6_mtu = ipv6_mtu_ff;

   // Stage 1: classify and check
   icmp64_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .msg_type (req_chan.msg_type),
      .msg_code (req_chan.msg_code),
      .rest_in  (req_chan.rest_in),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_item  (s1_item)
   );

   // Stage 2: MTU clamp
   icmp64_mtu u_mtu (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_item  (s1_item),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_item  (s2_item)
   );

   // Stage 3: assemble result, output register
   icmp64_out u_out (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_item  (s2_item),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_res   (res)
   );

   assign rsp_chan.accepted         = res.accepted;
   assign rsp_chan.icmp4_type       = res.icmp4_type;
   assign rsp_chan.icmp4_code       = res.icmp4_code;
   assign rsp_chan.rest_out         = res.rest_out;
   assign rsp_chan.is_error_message = res.is_error_message;

   // A rejected item carries nothing but zeros.
   `ICMP64_ASSERT_IMP(a_reject_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.accepted,
      rsp_chan.icmp4_type == '0 && rsp_chan.icmp4_code == '0 &&
      rsp_chan.rest_out == '0 && !rsp_chan.is_error_message)

   // A translated packet-too-big MTU never falls below the floor.
   `ICMP64_ASSERT_IMP(a_ptb_floor, clock, reset,
      rsp_chan.valid && rsp_chan.accepted &&
      rsp_chan.icmp4_type == icmp64_pkg::V4_DEST_UNREACH &&
      rsp_chan.icmp4_code == icmp64_pkg::V4C_FRAG_NEEDED,
      rsp_chan.rest_out[31:16] == 16'd0 &&
      rsp_chan.rest_out[15:0] >= icmp64_pkg::MTU_FLOOR)

   // Only echo types come out as non-error messages.
   `ICMP64_ASSERT_IMP(a_echo_types, clock, reset,
      rsp_chan.valid && rsp_chan.accepted && !rsp_chan.is_error_message,
      (rsp_chan.icmp4_type == icmp64_pkg::V4_ECHO_REQ ||
       rsp_chan.icmp4_type == icmp64_pkg::V4_ECHO_REP) &&
      rsp_chan.icmp4_code == icmp64_pkg::V4C_ZERO)

   // A write to the IPv4 link MTU lands in its register.
   `ICMP64_ASSERT_NXT(a_csr_v4, clock, reset,
      csr_we && csr_index == icmp64_pkg::CSR_IPV4_LINK_MTU,
      ipv4_mtu_ff == $past(csr_wdata))

endmodule
